[design/sit_pkg.sv]
// Shared types and codes for the sorted identifier table.
// No dependencies; imported by every module of the block but sit_ram.
`default_nettype none

package sit_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int DEFAULT_ID_BITS     = 16;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // stored entry relative to the command identifier
   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } cmp_result_type;

endpackage

`default_nettype wire

[design/sit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sit_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/sit_cmp.sv]
// Shared magnitude comparator used by both the insert scan and the binary search.
// Depends on sit_pkg.
`default_nettype none

module sit_cmp #(
   parameter int ID_BITS = sit_pkg::DEFAULT_ID_BITS
) (
   input  wire logic [ID_BITS-1:0]   entry,
   input  wire logic [ID_BITS-1:0]   key,
   output sit_pkg::cmp_result_type   result
);
   import sit_pkg::*;

   always_comb begin
      result.lt = entry < key;
      result.eq = entry == key;
      result.gt = entry > key;
   end

endmodule

`default_nettype wire

[design/sit_seq.sv]
// Command sequencer: scan, binary search and one-entry-per-step shifting of the table.
// Depends on sit_pkg; drives sit_ram and reads sit_cmp through the top level.
`default_nettype none

module sit_seq #(
   parameter int TABLE_DEPTH = sit_pkg::DEFAULT_TABLE_DEPTH,
   parameter int ID_BITS     = sit_pkg::DEFAULT_ID_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [sit_pkg::CMD_W-1:0]      req_command,
   input  wire logic [ID_BITS-1:0]             req_ident,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [sit_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [sit_pkg::POS_W-1:0]      rsp_position,
   output logic      [sit_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic                                ram_wr_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
   output logic      [ID_BITS-1:0]             ram_wr_data,
   output logic                                ram_rd_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
   input  wire logic [ID_BITS-1:0]             ram_rd_data,
   output logic      [ID_BITS-1:0]             key,
   input  wire sit_pkg::cmp_result_type        cmp
);
   import sit_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      IDLE, SCAN_RD, SCAN_CMP, INS_RD, INS_WR, INS_PUT,
      BS_RD, BS_CMP, REM_RD, REM_WR, RESULT
   } state_type;

   state_type            state_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     low_ff;
   logic [CNT_W-1:0]     hix_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [POS_W-1:0]     rsp_position_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [CNT_W-1:0]     idx_dec;
   logic [CNT_W-1:0]     idx_inc;
   logic [CNT_W:0]       idx_inc2;
   logic [CNT_W-1:0]     span;
   logic [CNT_W-1:0]     mid;
   logic                 search_open;
   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   logic [31:0]          pos_ext;
   logic [31:0]          count_ext;

   assign accept      = req_valid && (state_ff == IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == RESULT) && out_free;
   assign idx_dec     = idx_ff - CNT_W'(1);
   assign idx_inc     = idx_ff + CNT_W'(1);
   assign idx_inc2    = {1'b0, idx_ff} + (CNT_W + 1)'(2);
   assign search_open = low_ff < hix_ff;
   assign span        = hix_ff - low_ff - CNT_W'(1);
   assign mid         = low_ff + (span >> 1);
   assign pos_ext     = 32'(pos_ff);
   assign count_ext   = 32'(count_ff);
   assign key         = id_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         SCAN_RD: begin
            ram_rd_en = 1'b1;
         end
         INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dec[AW-1:0];
         end
         INS_WR, REM_WR: begin
            ram_wr_en = 1'b1;
         end
         INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = id_ff;
         end
         BS_RD: begin
            ram_rd_en   = search_open;
            ram_rd_addr = mid[AW-1:0];
         end
         REM_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_inc[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  id_ff         <= req_ident;
                  pos_ff        <= '0;
                  res_status_ff <= ST_DONE;
                  case (req_command)
                     CMD_INSERT: begin
                        if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= RESULT;
                        end else if (count_ff == '0) begin
                           state_ff <= INS_PUT;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= SCAN_RD;
                        end
                     end
                     CMD_REMOVE: begin
                        low_ff   <= '0;
                        hix_ff   <= count_ff;
                        state_ff <= BS_RD;
                     end
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= RESULT;
                     end
                     default: begin
                        state_ff <= RESULT;
                     end
                  endcase
               end
            end
            SCAN_RD: begin
               state_ff <= SCAN_CMP;
            end
            SCAN_CMP: begin
               if (cmp.gt) begin
                  pos_ff   <= idx_ff;
                  idx_ff   <= count_ff;
                  state_ff <= INS_RD;
               end else if (idx_inc == count_ff) begin
                  pos_ff   <= count_ff;
                  state_ff <= INS_PUT;
               end else begin
                  idx_ff   <= idx_inc;
                  state_ff <= SCAN_RD;
               end
            end
            INS_RD: begin
               state_ff <= INS_WR;
            end
            INS_WR: begin
               idx_ff   <= idx_dec;
               state_ff <= (idx_dec > pos_ff) ? INS_RD : INS_PUT;
            end
            INS_PUT: begin
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= RESULT;
            end
            BS_RD: begin
               if (search_open) begin
                  idx_ff   <= mid;
                  state_ff <= BS_CMP;
               end else begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= RESULT;
               end
            end
            BS_CMP: begin
               if (cmp.eq) begin
                  pos_ff <= idx_ff;
                  if (idx_inc < count_ff) begin
                     state_ff <= REM_RD;
                  end else begin
                     count_ff <= count_ff - CNT_W'(1);
                     state_ff <= RESULT;
                  end
               end else if (cmp.lt) begin
                  low_ff   <= idx_inc;
                  state_ff <= BS_RD;
               end else begin
                  hix_ff   <= idx_ff;
                  state_ff <= BS_RD;
               end
            end
            REM_RD: begin
               state_ff <= REM_WR;
            end
            REM_WR: begin
               idx_ff <= idx_inc;
               if (idx_inc2 < {1'b0, count_ff}) begin
                  state_ff <= REM_RD;
               end else begin
                  count_ff <= count_ff - CNT_W'(1);
                  state_ff <= RESULT;
               end
            end
            RESULT: begin
               if (out_free) begin
                  rsp_status_ff   <= res_status_ff;
                  rsp_position_ff <= pos_ext[POS_W-1:0];
                  rsp_count_ff    <= count_ext[COUNT_W-1:0];
                  state_ff        <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall       = state_ff != IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

[design/sorted_id_table_top.sv]
// Operation: insert scans for the first larger entry, shifts the entries from there up and
//   writes the new one (full is reported without a scan); remove binary-searches and shifts
//   later entries down; clear and unused codes go straight to the result stage.
// Throughput: one command at a time; a stalled result holds the block busy, and the next
//   command can be taken in the cycle in which rsp_valid rises.
// Reset (sync, active high) empties the table, RAM not cleared. Uses sit_pkg/ram/cmp/seq.
`default_nettype none

module sorted_id_table_top #(
   parameter int TABLE_DEPTH = sit_pkg::DEFAULT_TABLE_DEPTH,
   parameter int ID_BITS     = sit_pkg::DEFAULT_ID_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sit_pkg::CMD_W-1:0]    req_command,
   input  wire logic [ID_BITS-1:0]           req_ident,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [sit_pkg::STATUS_W-1:0] rsp_status,
   output logic      [sit_pkg::POS_W-1:0]    rsp_position,
   output logic      [sit_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import sit_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   // table RAM access, driven by the sequencer
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ID_BITS-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [ID_BITS-1:0] ram_rd_data;

   // shared comparator: registered RAM word against the command identifier
   logic [ID_BITS-1:0] key;
   cmp_result_type     cmp;

   sit_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sit_cmp #(
      .ID_BITS (ID_BITS)
   ) u_cmp (
      .entry  (ram_rd_data),
      .key    (key),
      .result (cmp)
   );

   // sequencer: linear scan for insert, binary search for remove,
   // then one read/write pair per shifted entry
   sit_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_ident       (req_ident),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .key             (key),
      .cmp             (cmp)
   );

endmodule

`default_nettype wire

[design/sit_checker.sv]
// Port-level assertions for the sorted identifier table, bound to the top level.
// Depends on sit_pkg and sorted_id_table_top.
`default_nettype none

module sit_checker #(
   parameter int TABLE_DEPTH = sit_pkg::DEFAULT_TABLE_DEPTH
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [sit_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [sit_pkg::POS_W-1:0]    rsp_position,
   input wire logic [sit_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import sit_pkg::*;

   // a result waiting on the consumer holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_entry_count))
      else $error("result changed while stalled");

   // the block is busy in the cycle after taking a command
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command taken without going busy");

   // failed commands report position zero
   a_fail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND)
         |-> rsp_position == '0)
      else $error("nonzero position on failed command");

   // count never beyond table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= TABLE_DEPTH)
      else $error("entry count beyond table depth");

   // no result in the cycle right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_id_table_top sit_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_sit_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire
